### rtl/tst_pkg.sv
// Package with the sizes, command and status codes and sequencer states of the timer slot table.
package tst_pkg;

  localparam int NUM_SLOTS    = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W        = $clog2(NUM_SLOTS + 1);
  localparam int RES_W        = $clog2(MAX_RESULTS + 1);
  localparam int CMP_W        = (CNT_W > 4) ? CNT_W : 4;
  localparam int TIME_W       = 64;
  localparam int SLOT_FIELD_W = 4;
  localparam int CMD_W        = 3;
  localparam int STATUS_W     = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ARM_ONESHOT  = 3'd0,
    CMD_ARM_PERIODIC = 3'd1,
    CMD_CANCEL       = 3'd2,
    CMD_MODIFY       = 3'd3,
    CMD_TICK         = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_FREE     = 2'd1,
    STAT_INACTIVE    = 2'd2,
    STAT_ZERO_PERIOD = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ARM,
    S_EDIT,
    S_TICK_RD,
    S_TICK_CMP,
    S_RESP
  } state_t;

endpackage

### rtl/tst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/timer_slot_table.sv
// Top level of the timer slot table: command sequencer, slot flags and deadline/period RAMs.
//
// The block keeps NUM_SLOTS software timers. Commands arrive as beats on the in_ channel
// (command in in_tuser, operands in in_tdata) and each command produces one or more
// result beats on the out_ channel; out_tlast marks the final beat of a command.
// Arm commands take the lowest free slot, cancel and modify act on the named slot,
// and a tick compares the current time with every active slot in slot order and
// reports each expired timer in its own beat (or one empty beat if none expired).
//
// in_tready is high only while the sequencer is idle. Cancel and modify pass through the
// edit state to the result register; an unknown command and a zero-period arm periodic go
// straight from idle to the response state. An arm walks the slot flags one slot per cycle.
// A tick reads the deadline and period RAMs one slot at a time: a read state for the
// registered RAM read, then a compare state for the shared 64-bit compare and add.
//
// Reset clears all active and periodic flags, so every slot is free; the RAM contents
// are not cleared, since a slot's entries are always written when it is armed.
// When the receiver stalls, the finished beat waits in the output register; a tick that
// finds another expiry while a beat is still waiting holds until the beat is taken.
module timer_slot_table
  import tst_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // in_tdata: slot [3:0], time_value [67:4], period_value [131:68], now [195:132].
  input  logic [199:0] in_tdata,
  // in_tuser: command [2:0].
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_tdata: status [1:0], result_slot [5:2].
  output logic [7:0]   out_tdata,
  // out_tuser: expired [0].
  output logic [0:0]   out_tuser,
  output logic         out_tlast
);

  state_t                  state_r, state_nxt;
  cmd_t                    cmd_r, cmd_nxt;
  logic [SLOT_FIELD_W-1:0] slot_r, slot_nxt;
  logic [TIME_W-1:0]       tv_r, tv_nxt;
  logic [TIME_W-1:0]       pv_r, pv_nxt;
  logic [TIME_W-1:0]       now_r, now_nxt;
  logic [CNT_W-1:0]        idx_r, idx_nxt;
  logic [NUM_SLOTS-1:0]    active_r, active_nxt;
  logic [NUM_SLOTS-1:0]    periodic_r, periodic_nxt;
  logic                    pend_r, pend_nxt;
  logic [SLOT_FIELD_W-1:0] pend_slot_r, pend_slot_nxt;
  logic [RES_W-1:0]        cnt_r, cnt_nxt;

  status_t                 res_status_r, res_status_nxt;
  logic [SLOT_FIELD_W-1:0] res_slot_r, res_slot_nxt;
  logic                    res_exp_r, res_exp_nxt;

  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [SLOT_FIELD_W-1:0] out_slot_r, out_slot_nxt;
  logic                    out_exp_r, out_exp_nxt;
  logic                    out_last_r, out_last_nxt;

  logic              dl_we, per_we;
  logic [SLOT_W-1:0] dl_waddr, per_waddr, ram_raddr;
  logic [TIME_W-1:0] dl_wdata, per_wdata, dl_rdata, per_rdata;

  logic              out_free;
  logic              idx_last;
  logic [SLOT_W-1:0] idx_slot;
  logic [SLOT_W-1:0] cmd_slot;
  logic              edit_ok;
  logic              tick_hit;

  tst_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_deadline_ram (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .raddr (ram_raddr),
    .rdata (dl_rdata)
  );

  tst_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_period_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (per_waddr),
    .wdata (per_wdata),
    .raddr (ram_raddr),
    .rdata (per_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_slot_r, out_status_r};
  assign out_tuser  = out_exp_r;
  assign out_tlast  = out_last_r;

  assign out_free  = !out_valid_r || out_tready;
  assign idx_slot  = idx_r[SLOT_W-1:0];
  assign idx_last  = (idx_r == CNT_W'(NUM_SLOTS - 1));
  assign cmd_slot  = SLOT_W'(slot_r);
  assign ram_raddr = idx_slot;
  // A slot number beyond the table counts as an inactive slot.
  assign edit_ok   = (CMP_W'(slot_r) < CMP_W'(NUM_SLOTS)) && active_r[cmd_slot];
  // The shared compare: an active slot has expired once now reaches its deadline.
  assign tick_hit  = active_r[idx_slot] && (now_r >= dl_rdata);

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    slot_nxt       = slot_r;
    tv_nxt         = tv_r;
    pv_nxt         = pv_r;
    now_nxt        = now_r;
    idx_nxt        = idx_r;
    active_nxt     = active_r;
    periodic_nxt   = periodic_r;
    pend_nxt       = pend_r;
    pend_slot_nxt  = pend_slot_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_exp_nxt    = res_exp_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_exp_nxt    = out_exp_r;
    out_last_nxt   = out_last_r;
    dl_we          = 1'b0;
    dl_waddr       = idx_slot;
    dl_wdata       = tv_r;
    per_we         = 1'b0;
    per_waddr      = idx_slot;
    per_wdata      = tv_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt        = cmd_t'(in_tuser);
          slot_nxt       = in_tdata[3:0];
          tv_nxt         = in_tdata[67:4];
          pv_nxt         = in_tdata[131:68];
          now_nxt        = in_tdata[195:132];
          idx_nxt        = '0;
          pend_nxt       = 1'b0;
          cnt_nxt        = '0;
          res_status_nxt = STAT_OK;
          res_slot_nxt   = '0;
          res_exp_nxt    = 1'b0;
          case (cmd_t'(in_tuser))
            CMD_ARM_ONESHOT: state_nxt = S_ARM;
            CMD_ARM_PERIODIC: begin
              // The zero period check comes before the free slot search.
              if (in_tdata[67:4] == '0) begin
                res_status_nxt = STAT_ZERO_PERIOD;
                state_nxt      = S_RESP;
              end else begin
                state_nxt = S_ARM;
              end
            end
            CMD_CANCEL, CMD_MODIFY: state_nxt = S_EDIT;
            CMD_TICK:               state_nxt = S_TICK_RD;
            default:                state_nxt = S_RESP;
          endcase
        end
      end

      S_ARM: begin
        if (!active_r[idx_slot]) begin
          active_nxt[idx_slot]   = 1'b1;
          periodic_nxt[idx_slot] = (cmd_r == CMD_ARM_PERIODIC);
          dl_we                  = 1'b1;
          per_we                 = 1'b1;
          per_wdata              = (cmd_r == CMD_ARM_PERIODIC) ? tv_r : '0;
          res_status_nxt         = STAT_OK;
          res_slot_nxt           = SLOT_FIELD_W'(idx_r);
          state_nxt              = S_RESP;
        end else if (idx_last) begin
          res_status_nxt = STAT_NO_FREE;
          state_nxt      = S_RESP;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_EDIT: begin
        res_slot_nxt = slot_r;
        state_nxt    = S_RESP;
        if (!edit_ok) begin
          res_status_nxt = STAT_INACTIVE;
        end else begin
          res_status_nxt = STAT_OK;
          if (cmd_r == CMD_CANCEL) begin
            active_nxt[cmd_slot]   = 1'b0;
            periodic_nxt[cmd_slot] = 1'b0;
          end else begin
            dl_we     = 1'b1;
            dl_waddr  = cmd_slot;
            per_we    = periodic_r[cmd_slot];
            per_waddr = cmd_slot;
            per_wdata = pv_r;
          end
        end
      end

      S_TICK_RD: begin
        state_nxt = S_TICK_CMP;
      end

      S_TICK_CMP: begin
        if (tick_hit) begin
          // The held expiry goes out now, since a later one follows it.
          if (!(pend_r && !out_free)) begin
            if (pend_r) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = STAT_OK;
              out_slot_nxt   = pend_slot_r;
              out_exp_nxt    = 1'b1;
              out_last_nxt   = 1'b0;
            end
            if (periodic_r[idx_slot]) begin
              dl_we    = 1'b1;
              dl_wdata = dl_rdata + per_rdata;
            end else begin
              active_nxt[idx_slot] = 1'b0;
            end
            pend_nxt      = 1'b1;
            pend_slot_nxt = SLOT_FIELD_W'(idx_r);
            cnt_nxt       = cnt_r + 1'b1;
            if (idx_last || (cnt_r == RES_W'(MAX_RESULTS - 1))) begin
              res_status_nxt = STAT_OK;
              res_slot_nxt   = SLOT_FIELD_W'(idx_r);
              res_exp_nxt    = 1'b1;
              state_nxt      = S_RESP;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = S_TICK_RD;
            end
          end
        end else if (idx_last) begin
          res_status_nxt = STAT_OK;
          res_slot_nxt   = pend_r ? pend_slot_r : '0;
          res_exp_nxt    = pend_r;
          state_nxt      = S_RESP;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_TICK_RD;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_exp_nxt    = res_exp_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      periodic_r  <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      idx_r       <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      periodic_r  <= periodic_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    slot_r       <= slot_nxt;
    tv_r         <= tv_nxt;
    pv_r         <= pv_nxt;
    now_r        <= now_nxt;
    pend_slot_r  <= pend_slot_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_exp_r    <= res_exp_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_exp_r    <= out_exp_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

### dv/tb.sv
// Self-checking testbench for the timer slot table: directed table, random commands, scoreboard.
module tb
  import tst_pkg::*;
();

  localparam logic [63:0] T_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [2:0] CMD_UNUSED_5 = 3'd5;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;
  localparam int RANDOM_CMDS = 276;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    status_t    status;
    logic [3:0] slot;
    logic       expired;
    logic       last;
  } beat_t;

  typedef struct {
    logic [2:0]  cmd;
    logic [3:0]  slot;
    logic [63:0] tv;
    logic [63:0] pv;
    logic [63:0] now;
    int          reps;
    bit          typed;
    beat_t       res;
  } cmd_item_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [199:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [7:0]   out_tdata;
  logic [0:0]   out_tuser;
  logic         out_tlast;

  // Typed expectation that travels along with the beat being offered.
  bit    drv_typed;
  beat_t drv_res;

  bit idle_on;
  bit hold_ask;
  int err_count;
  logic [63:0] clock_now;

  // Shadow copy of the slot table.
  logic        t_active   [NUM_SLOTS];
  logic        t_periodic [NUM_SLOTS];
  logic [63:0] t_deadline [NUM_SLOTS];
  logic [63:0] t_period   [NUM_SLOTS];

  beat_t     pending_beats [$];
  beat_t     fresh_beats [$];
  cmd_item_t dir_rows [$];

  timer_slot_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what, input beat_t got, input beat_t want);
    $display({"mismatch at %0t: %s got st=%0d slot=%0d exp=%0d last=%0d",
              " want st=%0d slot=%0d exp=%0d last=%0d"},
             $realtime, what, got.status, got.slot, got.expired, got.last,
             want.status, want.slot, want.expired, want.last);
    err_count++;
  endtask

  function automatic beat_t mk_beat(status_t st, logic [3:0] s, logic ex, logic lst);
    beat_t b;
    b.status  = st;
    b.slot    = s;
    b.expired = ex;
    b.last    = lst;
    return b;
  endfunction

  // Applies one command to the shadow table and leaves its result beats in fresh_beats.
  task automatic apply_command(input logic [2:0] c, input logic [3:0] s, input logic [63:0] tv,
                               input logic [63:0] pv, input logic [63:0] nw);
    int  i;
    bit  found;
    fresh_beats.delete();
    found = 0;
    case (c)
      CMD_ARM_ONESHOT, CMD_ARM_PERIODIC: begin
        // The zero period check wins even when the table is full.
        if (c == CMD_ARM_PERIODIC && tv == '0) begin
          fresh_beats.push_back(mk_beat(STAT_ZERO_PERIOD, 4'd0, 1'b0, 1'b1));
        end else begin
          for (i = 0; i < NUM_SLOTS && !found; i++) begin
            if (!t_active[i]) begin
              found = 1;
              t_active[i]   = 1'b1;
              t_periodic[i] = (c == CMD_ARM_PERIODIC);
              t_deadline[i] = tv;
              t_period[i]   = (c == CMD_ARM_PERIODIC) ? tv : '0;
              fresh_beats.push_back(mk_beat(STAT_OK, i[3:0], 1'b0, 1'b1));
            end
          end
          if (!found) fresh_beats.push_back(mk_beat(STAT_NO_FREE, 4'd0, 1'b0, 1'b1));
        end
      end
      CMD_CANCEL, CMD_MODIFY: begin
        if (!t_active[s]) begin
          fresh_beats.push_back(mk_beat(STAT_INACTIVE, s, 1'b0, 1'b1));
        end else begin
          if (c == CMD_CANCEL) begin
            t_active[s]   = 1'b0;
            t_periodic[s] = 1'b0;
          end else begin
            t_deadline[s] = tv;
            if (t_periodic[s]) t_period[s] = pv;
          end
          fresh_beats.push_back(mk_beat(STAT_OK, s, 1'b0, 1'b1));
        end
      end
      CMD_TICK: begin
        for (i = 0; i < NUM_SLOTS && fresh_beats.size() < MAX_RESULTS; i++) begin
          if (t_active[i] && nw >= t_deadline[i]) begin
            if (t_periodic[i]) t_deadline[i] = t_deadline[i] + t_period[i];
            else t_active[i] = 1'b0;
            fresh_beats.push_back(mk_beat(STAT_OK, i[3:0], 1'b1,
                                          1'b0));
          end
        end
        if (fresh_beats.size() == 0) begin
          fresh_beats.push_back(mk_beat(STAT_OK, 4'd0, 1'b0, 1'b1));
        end else begin
          fresh_beats[fresh_beats.size()-1] = mk_beat(STAT_OK,
              fresh_beats[fresh_beats.size()-1].slot, 1'b1, 1'b1);
        end
      end
      default: fresh_beats.push_back(mk_beat(STAT_OK, 4'd0, 1'b0, 1'b1));
    endcase
  endtask

  // Scoreboard: output beats are checked before the accepted command is predicted.
  always @(posedge clk) begin : scoreboard
    beat_t got;
    beat_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = mk_beat(status_t'(out_tdata[1:0]), out_tdata[5:2], out_tuser[0], out_tlast);
        if (pending_beats.size() == 0) begin
          report_mismatch("beat with nothing pending", got, got);
        end else begin
          want = pending_beats.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.expired !== want.expired || got.last !== want.last)
            report_mismatch("field", got, want);
        end
      end
      if (in_tvalid && in_tready) begin
        apply_command(in_tuser, in_tdata[3:0], in_tdata[67:4], in_tdata[131:68],
                      in_tdata[195:132]);
        if (drv_typed) pending_beats.push_back(drv_res);
        else foreach (fresh_beats[i]) pending_beats.push_back(fresh_beats[i]);
      end
    end
  end

  // Receiver: random back-pressure plus one long hold once asked.
  initial begin : receiver
    bit hold_done;
    int hold_cnt;
    out_tready = 1'b0;
    hold_done  = 0;
    forever begin
      @(negedge clk);
      if (hold_ask && !hold_done) begin
        hold_done  = 1;
        out_tready <= 1'b0;
        hold_cnt   = 0;
        while (hold_cnt < HOLD_CYCLES) begin
          @(negedge clk);
          hold_cnt++;
        end
      end else if (idle_on && $urandom_range(99) < 29) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(input cmd_item_t it);
    while (idle_on && $urandom_range(99) < 29) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.cmd;
    in_tdata  <= {4'b0, it.now, it.pv, it.tv, it.slot};
    drv_typed <= it.typed;
    drv_res   <= it.res;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic void add_row(logic [2:0] c, logic [3:0] s, logic [63:0] tv,
                                  logic [63:0] pv, logic [63:0] nw, int reps, bit typed,
                                  status_t st, logic [3:0] rs);
    cmd_item_t it;
    it.cmd   = c;
    it.slot  = s;
    it.tv    = tv;
    it.pv    = pv;
    it.now   = nw;
    it.reps  = reps;
    it.typed = typed;
    it.res   = mk_beat(st, rs, 1'b0, 1'b1);
    dir_rows.push_back(it);
  endfunction

  // Mostly an active slot, so that cancel and modify do real work.
  function automatic logic [3:0] pick_slot();
    int busy [$];
    foreach (t_active[i]) if (t_active[i]) busy.push_back(i);
    if (busy.size() > 0 && $urandom_range(99) < 80)
      return 4'(busy[$urandom_range(busy.size() - 1)]);
    return 4'($urandom_range(NUM_SLOTS - 1));
  endfunction

  // Deadlines sit just ahead of the running clock so that ticks keep expiring timers.
  function automatic logic [63:0] near_deadline();
    if ($urandom_range(99) < 10) return rand64();
    return clock_now + 64'($urandom_range(120));
  endfunction

  function automatic cmd_item_t gen_item();
    cmd_item_t it;
    int r;
    it.slot  = 4'($urandom_range(15));
    it.tv    = rand64();
    it.pv    = rand64();
    it.now   = rand64();
    it.reps  = 1;
    it.typed = 0;
    it.res   = '0;
    r = $urandom_range(99);
    if (r < 20) begin
      it.cmd = CMD_ARM_ONESHOT;
      it.tv  = near_deadline();
    end else if (r < 36) begin
      it.cmd = CMD_ARM_PERIODIC;
      r = $urandom_range(99);
      if (r < 6) it.tv = '0;
      else if (r < 90) it.tv = 64'($urandom_range(1, 60));
    end else if (r < 50) begin
      it.cmd  = CMD_CANCEL;
      it.slot = pick_slot();
    end else if (r < 62) begin
      it.cmd  = CMD_MODIFY;
      it.slot = pick_slot();
      it.tv   = near_deadline();
      if ($urandom_range(99) < 90) it.pv = 64'($urandom_range(60));
    end else if (r < 96) begin
      it.cmd = CMD_TICK;
      r = $urandom_range(99);
      if (r < 3) begin
        // Jump close to the top of the range so deadlines and periods wrap.
        clock_now = T_MAX - 64'($urandom_range(200));
        it.now = clock_now;
      end else if (r < 90) begin
        clock_now = clock_now + 64'($urandom_range(40));
        it.now = clock_now;
      end
    end else begin
      it.cmd = 3'($urandom_range(CMD_UNUSED_5, CMD_UNUSED_7));
    end
    return it;
  endfunction

  initial begin : stimulus
    int k;
    int r;
    int wait_cnt;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    drv_typed = 0;
    drv_res   = '0;
    idle_on   = 1;
    hold_ask  = 0;
    err_count = 0;
    clock_now = '0;
    foreach (t_active[i]) begin
      t_active[i]   = 1'b0;
      t_periodic[i] = 1'b0;
      t_deadline[i] = '0;
      t_period[i]   = '0;
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(CMD_TICK, 4'd0, '0, '0, '0, 1, 1, STAT_OK, 4'd0);
    add_row(CMD_CANCEL, 4'd5, '0, '0, '0, 1, 1, STAT_INACTIVE, 4'd5);
    add_row(CMD_MODIFY, 4'd15, T_MAX, T_MAX, T_MAX, 1, 1, STAT_INACTIVE, 4'd15);
    add_row(CMD_ARM_PERIODIC, 4'd15, '0, T_MAX, T_MAX, 1, 1, STAT_ZERO_PERIOD, 4'd0);
    add_row(CMD_UNUSED_5, 4'd15, T_MAX, T_MAX, T_MAX, 1, 1, STAT_OK, 4'd0);
    add_row(CMD_UNUSED_7, 4'd10, T_MAX, '0, T_MAX, 1, 1, STAT_OK, 4'd0);
    add_row(CMD_ARM_ONESHOT, 4'd0, '0, '0, '0, 1, 1, STAT_OK, 4'd0);
    add_row(CMD_ARM_PERIODIC, 4'd0, T_MAX, '0, '0, 1, 1, STAT_OK, 4'd1);
    add_row(CMD_ARM_ONESHOT, 4'd0, 64'd100, '0, '0, 1, 1, STAT_OK, 4'd2);
    add_row(CMD_ARM_PERIODIC, 4'd0, 64'd10, '0, '0, 1, 1, STAT_OK, 4'd3);
    // Modify of a one-shot only moves its deadline.
    add_row(CMD_MODIFY, 4'd2, 64'd50, 64'd7, '0, 1, 1, STAT_OK, 4'd2);
    // A periodic slot may be given a period of zero.
    add_row(CMD_MODIFY, 4'd3, 64'd20, '0, '0, 1, 1, STAT_OK, 4'd3);
    add_row(CMD_TICK, 4'd0, '0, '0, 64'd19, 1, 0, STAT_OK, 4'd0);
    add_row(CMD_TICK, 4'd0, '0, '0, T_MAX, 1, 0, STAT_OK, 4'd0);
    add_row(CMD_ARM_ONESHOT, 4'd0, T_MAX, '0, '0, NUM_SLOTS - 2, 0, STAT_OK, 4'd0);
    // The table is full now; a zero period still reports its own error.
    add_row(CMD_ARM_ONESHOT, 4'd0, 64'd1, '0, '0, 1, 1, STAT_NO_FREE, 4'd0);
    add_row(CMD_ARM_PERIODIC, 4'd0, 64'd5, '0, '0, 1, 1, STAT_NO_FREE, 4'd0);
    add_row(CMD_ARM_PERIODIC, 4'd0, '0, '0, '0, 1, 1, STAT_ZERO_PERIOD, 4'd0);
    // Every slot expires on this tick, the most beats one command can give.
    add_row(CMD_TICK, 4'd0, '0, '0, T_MAX, 1, 0, STAT_OK, 4'd0);
    add_row(CMD_CANCEL, 4'd1, '0, '0, '0, 1, 1, STAT_OK, 4'd1);
    add_row(CMD_CANCEL, 4'd1, '0, '0, '0, 1, 1, STAT_INACTIVE, 4'd1);

    @(negedge clk);
    foreach (dir_rows[k])
      for (r = 0; r < dir_rows[k].reps; r++) send_item(dir_rows[k]);

    for (k = 0; k < RANDOM_CMDS; k++) begin
      idle_on <= !(k >= 150 && k < 210);
      if (k == 60) hold_ask <= 1'b1;
      send_item(gen_item());
    end
    in_tvalid <= 1'b0;

    wait_cnt = 0;
    while (pending_beats.size() != 0 && wait_cnt < 50000) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (pending_beats.size() != 0) begin
      $display("mismatch: %0d beats still pending at the end", pending_beats.size());
      err_count++;
    end
    repeat (2 * NUM_SLOTS + 8) @(posedge clk);

    if (err_count == 0) $display("[timer_slot_table] OK");
    else $display("[timer_slot_table] ERROR");
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("[timer_slot_table] ERROR");
    $finish;
  end

endmodule
